// ----- hw/rtl/plts_pkg.sv -----
// plts_pkg: shared types, codes and helpers for the plane tolerance snap table
// item structs, command codes, the token handed along the cell chain
// no dependencies
`default_nettype none

package plts_pkg;

	localparam int unsigned ENTRIES_DEF = 256;
	localparam int unsigned W           = 32;
	localparam int unsigned TOL_W       = 16;
	localparam int unsigned NCOMP       = 4;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd33;

	localparam logic [1:0] CMD_FIND  = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]          command;
		logic signed [W-1:0] normal_x;
		logic signed [W-1:0] normal_y;
		logic signed [W-1:0] normal_z;
		logic signed [W-1:0] distance;
	} cmd_item_t;

	typedef struct packed {
		logic                found;
		logic signed [W-1:0] snap_x;
		logic signed [W-1:0] snap_y;
		logic signed [W-1:0] snap_z;
		logic signed [W-1:0] snap_distance;
		logic                table_full;
	} res_item_t;

	typedef struct packed {
		logic [NCOMP-1:0]        hit;
		logic [NCOMP-1:0][W-1:0] word;
		logic [NCOMP-1:0][W-1:0] snap;
	} tok_t;

	function automatic logic within_tol(input logic [W-1:0] stored, input logic [W-1:0] value,
		input logic [TOL_W-1:0] tol);
		logic signed [W:0]   d;
		logic signed [W+1:0] dx;
		logic signed [W+1:0] ts;
		d  = $signed({stored[W-1], stored}) - $signed({value[W-1], value});
		dx = {d[W], d};
		ts = $signed({{(W+2-TOL_W){1'b0}}, tol});
		return (dx < ts) && (dx > -ts);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/plts_cell.sv -----
// plts_cell: one table slot for all four components plus one token stage
// compares the passing token against its entries and hands it on
// depends on plts_pkg
`default_nettype none

module plts_cell #(
	parameter int unsigned ENTRIES = plts_pkg::ENTRIES_DEF,
	localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int unsigned CNT_W  = $clog2(ENTRIES + 1)
) (
	input  wire logic                                       clk,
	input  wire logic [IDX_W-1:0]                           idx,
	input  wire logic [plts_pkg::NCOMP-1:0][CNT_W-1:0]      count,
	input  wire logic [plts_pkg::TOL_W-1:0]                 tol,
	input  wire logic [plts_pkg::NCOMP-1:0]                 wr_en,
	input  wire logic [plts_pkg::NCOMP-1:0][plts_pkg::W-1:0] wr_data,
	input  wire plts_pkg::tok_t                             tok_in,
	output plts_pkg::tok_t                                  tok_out
);
	import plts_pkg::*;

	logic [NCOMP-1:0][W-1:0] val_q;
	tok_t                    tok_q;
	tok_t                    tok_nx;
	logic [CNT_W-1:0]        idx_ext;

	assign idx_ext = CNT_W'(idx);

	always_comb begin
		tok_nx = tok_in;
		for (int c = 0; c < NCOMP; c++) begin
			if (!tok_in.hit[c] && (idx_ext < count[c])
				&& within_tol(val_q[c], tok_in.word[c], tol)) begin
				tok_nx.hit[c]  = 1'b1;
				tok_nx.snap[c] = val_q[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nx;
		for (int c = 0; c < NCOMP; c++) begin
			if (wr_en[c] && (idx_ext == count[c])) begin
				val_q[c] <= wr_data[c];
			end
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ----- hw/rtl/plane_tolerance_snap_table.sv -----
// plane_tolerance_snap_table_core: snaps plane components to stored values
// a row of plts_cell slots searched by a token walking the row
// depends on plts_pkg and plts_cell
//
// channel | signals                  | direction | payload
// cmd     | cmd_valid, cmd_stall     | in        | cmd_item_t
// res     | res_valid, res_stall     | out       | res_item_t
// cfg     | cfg_valid, cfg_ready     | in        | 16-bit tolerance
//
// one item at a time: the token walks all ENTRIES cells in ST_RUN, then ST_DONE
// appends the missing components and loads the result register
// cmd_stall stays high until the block returns to ST_IDLE, so no new item is taken before the last one is finished
// a stalled result holds the finish step until the output register frees
// arst_n clears counts, tolerance (to 33) and control; entries need no clearing
`default_nettype none

module plane_tolerance_snap_table_core #(
	parameter int unsigned ENTRIES = plts_pkg::ENTRIES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	output logic                              cmd_stall,
	input  wire plts_pkg::cmd_item_t          cmd,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output plts_pkg::res_item_t               res,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [plts_pkg::TOL_W-1:0]   cfg_data
);
	import plts_pkg::*;

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                      state_q;
	cmd_item_t                   item_q;
	logic [CNT_W-1:0]            run_q;
	logic [NCOMP-1:0][CNT_W-1:0] count_q;
	logic [NCOMP-1:0][CNT_W-1:0] count_d;
	logic [TOL_W-1:0]            tol_q;
	res_item_t                   res_q;
	res_item_t                   res_d;
	logic                        res_valid_q;
	logic [NCOMP-1:0]            wr_req;
	logic [NCOMP-1:0]            wr_en;
	logic                        accept;
	logic                        fire;
	tok_t                        head;
	tok_t                        chain [ENTRIES+1];
	tok_t                        fin;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign fire      = (state_q == ST_DONE) && (!res_valid_q || !res_stall);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		head.hit     = '0;
		head.word[0] = item_q.normal_x;
		head.word[1] = item_q.normal_y;
		head.word[2] = item_q.normal_z;
		head.word[3] = item_q.distance;
		head.snap    = head.word;
	end

	assign chain[0] = head;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		plts_cell #(
			.ENTRIES(ENTRIES)
		) u_cell (
			.clk    (clk),
			.idx    (IDX_W'(i)),
			.count  (count_q),
			.tol    (tol_q),
			.wr_en  (wr_en),
			.wr_data(fin.word),
			.tok_in (chain[i]),
			.tok_out(chain[i+1])
		);
	end

	assign fin   = chain[ENTRIES];
	assign wr_en = wr_req & {NCOMP{fire}};

	always_comb begin
		res_d   = '0;
		count_d = count_q;
		wr_req  = '0;
		if (item_q.command == CMD_CLEAR) begin
			count_d = '0;
		end else begin
			res_d.found         = &fin.hit;
			res_d.snap_x        = fin.snap[0];
			res_d.snap_y        = fin.snap[1];
			res_d.snap_z        = fin.snap[2];
			res_d.snap_distance = fin.snap[3];
			for (int c = 0; c < NCOMP; c++) begin
				if ((item_q.command == CMD_ADD) && !fin.hit[c]) begin
					if (count_q[c] < CNT_W'(ENTRIES)) begin
						wr_req[c]  = 1'b1;
						count_d[c] = count_q[c] + CNT_W'(1);
					end else begin
						res_d.table_full = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_q       <= '0;
			count_q     <= '0;
			tol_q       <= TOL_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
				count_q     <= count_d;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						run_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					run_q <= run_q + CNT_W'(1);
					if (run_q == CNT_W'(ENTRIES - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[0] <= CNT_W'(ENTRIES)) && (count_q[1] <= CNT_W'(ENTRIES))
		&& (count_q[2] <= CNT_W'(ENTRIES)) && (count_q[3] <= CNT_W'(ENTRIES)))
		else $error("table count beyond capacity");

	a_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (run_q == '0))
		else $error("accepted item did not start a pass");

	a_clear_counts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item_q.command == CMD_CLEAR) |=> (count_q == '0) && res_valid_q)
		else $error("clear did not empty the tables");

	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (run_q < CNT_W'(ENTRIES)))
		else $error("pass counter out of range");

endmodule

`default_nettype wire
